>>> src/growable_id_allocator_core_assert.svh
// assertion macros used by the id allocator datapath
`ifndef GROWABLE_ID_ALLOCATOR_CORE_ASSERT_SVH
`define GROWABLE_ID_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// a condition that must hold at every clock edge out of reset
`define GIA_ASSERT_ALWAYS(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error("id allocator check failed");

// when the antecedent holds, the consequent must hold on the same edge
`define GIA_ASSERT_IMPLY(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("id allocator check failed");

`else

`define GIA_ASSERT_ALWAYS(label, clock, reset, cond)
`define GIA_ASSERT_IMPLY(label, clock, reset, ante, cons)

`endif

`endif

>>> src/gia_pkg.sv
// shared types and constants of the id allocator
package gia_pkg;

  localparam int MAX_IDS = 1024;
  localparam int ID_W    = 10;
  localparam int CNT_W   = 11;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  localparam logic [1:0] GSEL_ZERO  = 2'd0;
  localparam logic [1:0] GSEL_TID   = 2'd1;
  localparam logic [1:0] GSEL_QUEUE = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       clr_step;
    logic       f_sel_q;
    logic       pop;
    logic       live_inc;
    logic       live_dec;
    logic       grow_start;
    logic       grow_step;
    logic       grow_end;
    logic       flag_cap;
    logic       ins_claim;
    logic       rel_free;
    logic       res_load;
    logic [1:0] res_status;
    logic [1:0] res_gsel;
  } gia_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_last;
    logic       fill_zero;
    logic       cap_full;
    logic       tid_range;
    logic       cap_le_tid;
    logic       grow_done;
    logic       occ;
  } gia_stat_t;

endpackage

>>> src/growable_id_allocator_core.sv
// top level of the growable id allocator
//
// hands out ids from a first-in first-out free queue whose pool grows in
// chunks of CHUNK_SIZE fresh ids up to 1024. a word is taken when start is
// high and busy is low; its one result appears for a single cycle with done
// high and cannot be held off, so the receiver must take it then. after
// reset the block runs a clearing pass over the per-id flag memory with busy
// high. an allocate skips every stale queue entry that it meets (an id
// claimed by insert while still queued), and allocate and insert grow the
// pool a chunk at a time as needed; the growth loop writes one fresh id per
// cycle, skipping an id that an insert claims, into the single write port
// of the queue memory. busy drops in the cycle that done is high, so a new
// word may be taken alongside a result.
module growable_id_allocator_core import gia_pkg::*; #(
  parameter int CHUNK_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       opcode,
  input  logic [ID_W-1:0]  target_id,
  output logic             done,
  output logic [ID_W-1:0]  granted_id,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] live_count
);

  // command and status between sequencer and datapath
  gia_cmd_t  cmd;
  gia_stat_t stat;

  // sequencer: clearing pass, dispatch, stale-entry skipping, growth loop
  gia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: queue and flag memories, pointers, capacity, live count
  gia_datapath #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .target_id  (target_id),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .granted_id (granted_id),
    .status     (status),
    .live_count (live_count)
  );

endmodule

>>> src/gia_datapath.sv
// id allocator datapath: free queue, flag memory, counters and result registers
module gia_datapath import gia_pkg::*; #(
  parameter int CHUNK_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       opcode,
  input  logic [ID_W-1:0]  target_id,
  input  gia_cmd_t         cmd,
  output gia_stat_t        stat,
  output logic             done,
  output logic [ID_W-1:0]  granted_id,
  output logic [1:0]       status,
  output logic [CNT_W-1:0] live_count
);

  `include "growable_id_allocator_core_assert.svh"

  localparam int TOP_W = CNT_W + 1;
  localparam logic [ID_W-1:0]  ID_LAST = ID_W'(MAX_IDS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IDS);

  // flag word per id: occupied, queued
  logic [1:0]       flag_mem [MAX_IDS];
  logic [ID_W-1:0]  queue_mem [MAX_IDS];

  logic [1:0]       op;
  logic [ID_W-1:0]  tid;
  logic             tid_queued;
  logic [ID_W-1:0]  head, head_next;
  logic [ID_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] live;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] top;
  logic [ID_W-1:0]  clr_cnt;
  logic [TOP_W-1:0] top_sum;
  logic [CNT_W-1:0] top_next;

  logic [ID_W-1:0]  q_rdata;
  logic [1:0]       f_rdata;
  logic             q_we;
  logic [ID_W-1:0]  q_wdata;
  logic             f_we;
  logic [ID_W-1:0]  f_waddr;
  logic [1:0]       f_wdata;
  logic [ID_W-1:0]  f_raddr;
  logic             push;
  logic             grow_push;
  logic             grow_done;

  assign head_next = (head == ID_LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == ID_LAST) ? '0 : tail + 1'b1;

  assign top_sum  = {1'b0, cap} + TOP_W'(CHUNK_SIZE);
  assign top_next = (top_sum > TOP_W'(MAX_IDS)) ? CNT_MAX : top_sum[CNT_W-1:0];

  assign grow_done = (idx >= top);
  // the claimed id is held back from its own chunk
  assign grow_push = cmd.grow_step && !grow_done &&
                     !((op == OP_INSERT) && (idx == CNT_W'(tid)));

  assign push = grow_push || (cmd.rel_free && !f_rdata[0]);

  assign f_raddr = cmd.f_sel_q ? q_rdata : tid;

  always_comb begin
    q_we    = 1'b0;
    q_wdata = tid;
    f_we    = 1'b0;
    f_waddr = tid;
    f_wdata = 2'b00;
    priority if (cmd.clr_step) begin
      f_we    = 1'b1;
      f_waddr = clr_cnt;
      f_wdata = 2'b00;
    end else if (cmd.pop) begin
      // stale and granted entries both end up occupied and unqueued
      f_we    = 1'b1;
      f_waddr = q_rdata;
      f_wdata = 2'b10;
    end else if (grow_push) begin
      q_we    = 1'b1;
      q_wdata = idx[ID_W-1:0];
      f_we    = 1'b1;
      f_waddr = idx[ID_W-1:0];
      f_wdata = 2'b01;
    end else if (cmd.ins_claim) begin
      f_we    = 1'b1;
      f_wdata = {1'b1, tid_queued};
    end else if (cmd.rel_free) begin
      q_we    = !f_rdata[0];
      f_we    = 1'b1;
      f_wdata = 2'b01;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[tail] <= q_wdata;
    end
    q_rdata <= queue_mem[head];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      flag_mem[f_waddr] <= f_wdata;
    end
    f_rdata <= flag_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      fill    <= '0;
      cap     <= '0;
      live    <= '0;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.pop) begin
        head <= head_next;
        fill <= fill - 1'b1;
      end else if (push) begin
        tail <= tail_next;
        fill <= fill + 1'b1;
      end
      if (cmd.grow_end) begin
        cap <= top;
      end
      if (cmd.live_inc) begin
        live <= live + 1'b1;
      end else if (cmd.live_dec) begin
        live <= live - 1'b1;
      end
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op  <= opcode;
      tid <= target_id;
    end
    if (cmd.flag_cap) begin
      tid_queued <= f_rdata[0];
    end
    if (cmd.grow_start) begin
      idx <= cap;
      top <= top_next;
    end else if (cmd.grow_step && !grow_done) begin
      idx <= idx + 1'b1;
    end
    if (cmd.res_load) begin
      status <= cmd.res_status;
      unique case (cmd.res_gsel)
        GSEL_TID:   granted_id <= tid;
        GSEL_QUEUE: granted_id <= q_rdata;
        default:    granted_id <= '0;
      endcase
    end
  end

  assign live_count = live;

  assign stat.op         = op;
  assign stat.clr_last   = (clr_cnt == ID_LAST);
  assign stat.fill_zero  = (fill == '0);
  assign stat.cap_full   = (cap >= CNT_MAX);
  assign stat.tid_range  = ({1'b0, tid} >= CNT_MAX);
  assign stat.cap_le_tid = (cap <= CNT_W'(tid));
  assign stat.grow_done  = grow_done;
  assign stat.occ        = f_rdata[1];

  // fresh ids are queued before the capacity catches up at the end of growth
  `GIA_ASSERT_IMPLY(a_fill_le_cap, clk, rst, !(cmd.grow_step || cmd.grow_end), fill <= cap)
  `GIA_ASSERT_ALWAYS(a_live_le_cap, clk, rst, live <= cap)
  `GIA_ASSERT_ALWAYS(a_ring_span, clk, rst, ID_W'(tail - head) == fill[ID_W-1:0])
  `GIA_ASSERT_IMPLY(a_pop_nonempty, clk, rst, cmd.pop, fill != '0)

endmodule

>>> src/gia_ctrl.sv
// id allocator sequencer: clearing pass, opcode dispatch and growth loop
module gia_ctrl import gia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  gia_stat_t stat,
  output gia_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_QRD  = 4'd4;
  localparam logic [3:0] S_A_FRD  = 4'd5;
  localparam logic [3:0] S_GROW   = 4'd6;
  localparam logic [3:0] S_I_FRD  = 4'd7;
  localparam logic [3:0] S_I_GCHK = 4'd8;
  localparam logic [3:0] S_R_FRD  = 4'd9;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.op)
          OP_ALLOC: begin
            state_next = S_A_CHK;
          end
          OP_INSERT, OP_RELEASE: begin
            if (stat.tid_range) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_RANGE;
              cmd.res_gsel   = GSEL_TID;
              state_next     = S_IDLE;
            end else if (stat.op == OP_INSERT) begin
              state_next = S_I_FRD;
            end else begin
              state_next = S_R_FRD;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_gsel   = GSEL_ZERO;
            state_next     = S_IDLE;
          end
        endcase
      end
      S_A_CHK: begin
        priority if (!stat.fill_zero) begin
          state_next = S_A_QRD;
        end else if (stat.cap_full) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
          cmd.res_gsel   = GSEL_ZERO;
          state_next     = S_IDLE;
        end else begin
          cmd.grow_start = 1'b1;
          state_next     = S_GROW;
        end
      end
      S_A_QRD: begin
        cmd.f_sel_q = 1'b1;
        state_next  = S_A_FRD;
      end
      S_A_FRD: begin
        cmd.pop = 1'b1;
        if (stat.occ) begin
          state_next = S_A_CHK;
        end else begin
          cmd.live_inc   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_gsel   = GSEL_QUEUE;
          state_next     = S_IDLE;
        end
      end
      S_GROW: begin
        if (!stat.grow_done) begin
          cmd.grow_step = 1'b1;
        end else begin
          cmd.grow_end = 1'b1;
          state_next   = (stat.op == OP_ALLOC) ? S_A_CHK : S_I_GCHK;
        end
      end
      S_I_FRD: begin
        cmd.flag_cap = 1'b1;
        if (stat.occ) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_gsel   = GSEL_TID;
          state_next     = S_IDLE;
        end else begin
          state_next = S_I_GCHK;
        end
      end
      S_I_GCHK: begin
        if (stat.cap_le_tid) begin
          cmd.grow_start = 1'b1;
          state_next     = S_GROW;
        end else begin
          cmd.ins_claim  = 1'b1;
          cmd.live_inc   = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_gsel   = GSEL_TID;
          state_next     = S_IDLE;
        end
      end
      S_R_FRD: begin
        cmd.res_load = 1'b1;
        cmd.res_gsel = GSEL_TID;
        if (!stat.occ) begin
          cmd.res_status = ST_UNUSED;
        end else begin
          cmd.rel_free   = 1'b1;
          cmd.live_dec   = 1'b1;
          cmd.res_status = ST_OK;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> tb/growable_id_allocator_core_tb.sv
// self-checking testbench for the growable id allocator core
module growable_id_allocator_core_tb;
  import gia_pkg::*;

  localparam int CHUNK       = 32;
  // no word may take longer than the clearing pass plus a full walk over stale entries
  localparam int IDLE_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 50;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] tid;
  } word_t;

  typedef struct packed {
    logic [ID_W-1:0]  gid;
    logic [1:0]       st;
    logic [CNT_W-1:0] live;
  } grant_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       opcode = OP_ALLOC;
  logic [ID_W-1:0]  target_id = '0;
  logic             busy;
  logic             done;
  logic [ID_W-1:0]  granted_id;
  logic [1:0]       status;
  logic [CNT_W-1:0] live_count;

  growable_id_allocator_core #(
    .CHUNK_SIZE(CHUNK)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .target_id  (target_id),
    .done       (done),
    .granted_id (granted_id),
    .status     (status),
    .live_count (live_count)
  );

  always #6 clk = ~clk;

  // predictor state: circular free queue, pool size and per-id flags
  logic [ID_W-1:0] fq_mem [MAX_IDS];
  int              fq_head = 0;
  int              fq_tail = 0;
  int              fq_fill = 0;
  int              pool_cap = 0;
  int              live_n = 0;
  bit              in_use [MAX_IDS];
  bit              in_queue [MAX_IDS];

  word_t  word_q [$];   // words waiting to be driven
  grant_t grant_q [$];  // grants predicted but not yet seen
  int     fail_count = 0;
  int     idle_cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;

  // an id never sits in the queue twice, so the queue cannot overflow
  function automatic void fq_push(int id);
    if (in_queue[id] || fq_fill >= MAX_IDS) return;
    fq_mem[fq_tail] = ID_W'(id);
    fq_tail = (fq_tail + 1) % MAX_IDS;
    fq_fill++;
    in_queue[id] = 1'b1;
  endfunction

  function automatic int fq_pop();
    int id;
    id = int'(fq_mem[fq_head]);
    fq_head = (fq_head + 1) % MAX_IDS;
    fq_fill--;
    in_queue[id] = 1'b0;
    return id;
  endfunction

  // one chunk of fresh ids; the reserved id (if any) is being claimed and is skipped
  function automatic void grow_pool(int reserve);
    int top;
    top = pool_cap + CHUNK;
    if (top > MAX_IDS) top = MAX_IDS;
    for (int i = pool_cap; i < top; i++)
      if (i != reserve) fq_push(i);
    pool_cap = top;
  endfunction

  // advances the predictor by one word and returns the grant it should produce
  // (ids above the maximum cannot be encoded in ten bits, so no range error arises)
  function automatic grant_t predict_grant(word_t w);
    grant_t g;
    int     id;
    bit     settled;
    g.gid = '0;
    g.st  = ST_OK;
    id    = int'(w.tid);
    case (w.op)
      OP_ALLOC: begin
        settled = 1'b0;
        while (!settled) begin
          // drop entries already claimed by an insert
          while (fq_fill > 0 && in_use[fq_mem[fq_head]]) void'(fq_pop());
          if (fq_fill > 0 || pool_cap >= MAX_IDS) settled = 1'b1;
          else grow_pool(MAX_IDS);
        end
        if (fq_fill == 0) begin
          g.st = ST_FULL;
        end else begin
          id = fq_pop();
          g.gid = ID_W'(id);
          in_use[id] = 1'b1;
          live_n++;
        end
      end
      OP_INSERT: begin
        g.gid = w.tid;
        if (!in_use[id]) begin
          while (pool_cap <= id) grow_pool(id);
          in_use[id] = 1'b1;
          live_n++;
        end
      end
      OP_RELEASE: begin
        g.gid = w.tid;
        if (!in_use[id]) begin
          g.st = ST_UNUSED;
        end else begin
          in_use[id] = 1'b0;
          live_n--;
          fq_push(id);  // keeps its place if still queued
        end
      end
      default: ;
    endcase
    g.live = CNT_W'(live_n);
    return g;
  endfunction

  task automatic report_grant_error(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < 40)
      $display("grant mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  // driver: bursts of words with random gaps, start held until busy drops
  always @(posedge clk) begin : word_driver
    word_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) grant_q.push_back(predict_grant(word_t'({opcode, target_id})));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q.size() == 0) begin
          start <= 1'b0;
        end else begin
          nxt = word_q.pop_front();
          opcode    <= nxt.op;
          target_id <= nxt.tid;
          start     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  // monitor: every done cycle carries one grant, compared with the oldest prediction
  always @(posedge clk) begin : grant_monitor
    grant_t want;
    if (!rst && done) begin
      if (grant_q.size() == 0) begin
        report_grant_error("unexpected grant, id", 32'(granted_id), 0);
      end else begin
        want = grant_q.pop_front();
        if (granted_id !== want.gid)
          report_grant_error("granted_id", 32'(granted_id), 32'(want.gid));
        if (status !== want.st)
          report_grant_error("status", 32'(status), 32'(want.st));
        if (live_count !== want.live)
          report_grant_error("live_count", 32'(live_count), 32'(want.live));
      end
    end
  end

  // watchdog on cycles with no word taken and no grant seen
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  function automatic void queue_word(logic [1:0] op, int id);
    word_q.push_back(word_t'{op, ID_W'(id)});
  endfunction

  // some id in use, starting the search at a random place
  function automatic int any_live_id();
    int id;
    id = $urandom_range(0, MAX_IDS - 1);
    if (live_n == 0) return id;
    for (int n = 0; n < MAX_IDS; n++)
      if (in_use[(id + n) % MAX_IDS]) return (id + n) % MAX_IDS;
    return id;
  endfunction

  function automatic int pick_target();
    int id;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: id = any_live_id();
      4, 5:       id = (pool_cap > 0) ? $urandom_range(0, pool_cap - 1) : 0;
      6:          id = pool_cap + $urandom_range(0, 40);
      7:          id = $urandom_range(0, 1) ? 0 : MAX_IDS - 1;
      default:    id = $urandom_range(0, MAX_IDS - 1);
    endcase
    return (id > MAX_IDS - 1) ? MAX_IDS - 1 : id;
  endfunction

  // random words weighted by percentage; a small share uses the spare opcode
  function automatic void queue_mix(int n, int w_alloc, int w_ins);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 2) queue_word(OP_SPARE, $urandom_range(0, MAX_IDS - 1));
      else if (r < 2 + w_alloc) queue_word(OP_ALLOC, $urandom_range(0, MAX_IDS - 1));
      else if (r < 2 + w_alloc + w_ins) queue_word(OP_INSERT, pick_target());
      else queue_word(OP_RELEASE, pick_target());
    end
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (word_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: growth from empty, stale entries, claims and releases in every state
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, MAX_IDS - 1);
    queue_word(OP_INSERT, 5);         // claims an id still in the queue
    queue_word(OP_INSERT, 40);        // grows with the claimed id held back
    queue_word(OP_INSERT, 1);         // already in use
    queue_word(OP_RELEASE, 1);
    queue_word(OP_RELEASE, 1);        // now unused
    queue_word(OP_RELEASE, 7);        // never handed out
    queue_word(OP_ALLOC, 0);
    queue_word(OP_INSERT, 10);
    queue_word(OP_RELEASE, 10);       // still queued, keeps its place
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_ALLOC, 0);          // meets the stale entry for 5
    queue_word(OP_SPARE, MAX_IDS - 1);
    queue_word(OP_INSERT, MAX_IDS - 1); // grows right up to the maximum
    queue_word(OP_INSERT, 0);
    queue_word(OP_RELEASE, MAX_IDS - 1);
    queue_word(OP_RELEASE, 0);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_SPARE, 0);
    queue_word(OP_ALLOC, 0);
    queue_word(OP_RELEASE, MAX_IDS - 1);
    wait_drained();

    queue_mix(40, 50, 30);
    wait_drained();
    queue_mix(40, 35, 25);
    wait_drained();
    queue_mix(30, 55, 30);
    wait_drained();

    // fill the pool completely, then ask for more
    for (int k = live_n; k < MAX_IDS + 6; k++)
      queue_word(OP_ALLOC, $urandom_range(0, MAX_IDS - 1));
    wait_drained();

    queue_mix(30, 20, 20);
    wait_drained();
    queue_mix(30, 50, 20);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
